// ----- rtl/core/pidaw_pkg.sv -----
package pidaw_pkg;

	localparam int MeasW  = 16;
	localparam int ErrW   = MeasW + 1;
	localparam int GainW  = 24;
	localparam int LimW   = 23;
	localparam int DriveW = 24;
	localparam int IntW   = 32;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 24;

	localparam logic [LimW-1:0] LIMIT_RESET = 23'd786432;

	localparam logic [CfgIdxW-1:0] REG_SETPOINT  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KP_FAST   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KI_FAST   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KP_SLOW   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KI_SLOW   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_KD        = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_START_SET = 3'd7;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TOGGLE = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic signed [MeasW-1:0] measured_value;
	} sample_word_t;

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic                     clamped;
		logic                     active_set;
	} result_word_t;

endpackage

// ----- rtl/core/pidaw_ifs.sv -----
interface pidaw_sample_if;
	logic                   valid;
	logic                   ready;
	pidaw_pkg::sample_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pidaw_result_if;
	logic                   valid;
	logic                   ready;
	pidaw_pkg::result_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/pid_antiwindup_gain_switch_unit.sv -----
// channel  | dir | word                                   | handshake
// sample   | in  | cmd, measured_value                    | valid/ready
// result   | out | drive, clamped, active_set             | valid/ready
// cfg      | in  | cfg_index, cfg_data                    | cfg_wen, no back-pressure
//
// One word per cycle sustained while the result side is not stalled by result.ready.
// The error is formed into an input register, then P, I, D, the integral
// update and the clamp run in one pass into the result register, together
// with the controller state, so the next word sees the updated state.
// Async reset clears state and valids; a stalled result holds the input
// register, and a new sample is still taken whenever the input register frees.
module pid_antiwindup_gain_switch_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [pidaw_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [pidaw_pkg::CfgDataW-1:0]   cfg_data,
	pidaw_sample_if.sink                     sample,
	pidaw_result_if.source                   result
);
	import pidaw_pkg::*;

	// configuration
	logic signed [MeasW-1:0] setpoint_q;
	logic [GainW-1:0]        kp_fast_q, ki_fast_q, kp_slow_q, ki_slow_q, kd_q;
	logic [LimW-1:0]         out_limit_q;

	// controller state
	logic signed [IntW-1:0]   integral_q;
	logic signed [ErrW-1:0]   prev_err_q;
	logic signed [DriveW-1:0] last_drive_q;
	logic                     gain_sel_q;

	// input stage
	logic                   v_s1;
	logic                   cmd_s1;
	logic signed [ErrW-1:0] err_s1;

	logic         res_vld_q;
	result_word_t res_word_q;

	logic out_free, adv, take;

	assign out_free     = !res_vld_q || result.ready;
	assign adv          = v_s1 && out_free;
	assign sample.ready = !v_s1 || out_free;
	assign take         = sample.valid && sample.ready;
	assign result.valid = res_vld_q;
	assign result.data  = res_word_q;

	// datapath
	logic [GainW-1:0]         kp_sel, ki_sel;
	logic signed [ErrW:0]     err_diff;
	logic signed [41:0]       p_full, i_full;
	logic signed [42:0]       d_full;
	logic signed [33:0]       p_term, i_inc;
	logic signed [34:0]       d_term;
	logic signed [34:0]       acc;
	logic signed [IntW-1:0]   acc_sat;
	logic signed [LimW+1:0]   lim_x, last_x;
	logic                     room_up, room_dn, do_int;
	logic signed [IntW-1:0]   int_next;
	logic signed [36:0]       pid_sum, lim_w;
	logic signed [DriveW-1:0] drive_c;
	logic                     clamp_c;

	always_comb begin
		kp_sel   = gain_sel_q ? kp_slow_q : kp_fast_q;
		ki_sel   = gain_sel_q ? ki_slow_q : ki_fast_q;
		err_diff = 18'(err_s1) - 18'(prev_err_q);
		p_full   = $signed({1'b0, kp_sel}) * err_s1;
		i_full   = $signed({1'b0, ki_sel}) * err_s1;
		d_full   = $signed({1'b0, kd_q}) * err_diff;
		// floor shift to Q.16
		p_term   = p_full[41:8];
		i_inc    = i_full[41:8];
		d_term   = d_full[42:8];

		acc = 35'(integral_q) + 35'(i_inc);
		if (acc[34:31] != {4{acc[34]}}) begin
			acc_sat = acc[34] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
		end else begin
			acc_sat = acc[IntW-1:0];
		end

		lim_x   = $signed({2'b00, out_limit_q});
		last_x  = 25'(last_drive_q);
		room_up = (last_x < lim_x) && (err_s1 > 0);
		room_dn = (last_x > -lim_x) && (err_s1 < 0);
		do_int  = room_up || room_dn;
		int_next = do_int ? acc_sat : integral_q;

		pid_sum = 37'(p_term) + 37'(int_next) + 37'(d_term);
		lim_w   = $signed({14'd0, out_limit_q});
		if (pid_sum > lim_w) begin
			drive_c = DriveW'(lim_w);
			clamp_c = 1'b1;
		end else if (pid_sum < -lim_w) begin
			drive_c = DriveW'(-lim_w);
			clamp_c = 1'b1;
		end else begin
			drive_c = pid_sum[DriveW-1:0];
			clamp_c = 1'b0;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= '0;
			kp_fast_q   <= '0;
			ki_fast_q   <= '0;
			kp_slow_q   <= '0;
			ki_slow_q   <= '0;
			kd_q        <= '0;
			out_limit_q <= LIMIT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SETPOINT:  setpoint_q  <= cfg_data[MeasW-1:0];
				REG_KP_FAST:   kp_fast_q   <= cfg_data[GainW-1:0];
				REG_KI_FAST:   ki_fast_q   <= cfg_data[GainW-1:0];
				REG_KP_SLOW:   kp_slow_q   <= cfg_data[GainW-1:0];
				REG_KI_SLOW:   ki_slow_q   <= cfg_data[GainW-1:0];
				REG_KD:        kd_q        <= cfg_data[GainW-1:0];
				REG_OUT_LIMIT: out_limit_q <= cfg_data[LimW-1:0];
				// start set loads the gain select directly in the state block
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= sample.data.cmd;
			err_s1 <= 17'(setpoint_q) - 17'(sample.data.measured_value);
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_err_q   <= '0;
			last_drive_q <= '0;
			gain_sel_q   <= 1'b0;
			res_vld_q    <= 1'b0;
		end else begin
			if (adv) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
			if (cfg_wen && cfg_index == REG_START_SET) begin
				gain_sel_q <= cfg_data[0];
			end else if (adv && cmd_s1 == CMD_TOGGLE) begin
				gain_sel_q <= !gain_sel_q;
			end
			if (adv && cmd_s1 == CMD_SAMPLE) begin
				integral_q   <= int_next;
				prev_err_q   <= err_s1;
				last_drive_q <= drive_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				res_word_q.drive      <= drive_c;
				res_word_q.clamped    <= clamp_c;
				res_word_q.active_set <= gain_sel_q;
			end else begin
				res_word_q.drive      <= last_drive_q;
				res_word_q.clamped    <= 1'b0;
				res_word_q.active_set <= !gain_sel_q;
			end
		end
	end

endmodule
